// ===== rtl/rfp_pkg.sv =====
// rfp_pkg: shared types and codes for the response frame parser
// item structs, queue bundle, message kind and status codes; no dependencies
package rfp_pkg;

  localparam int LENGTH_WIDTH_DEF = 31;
  localparam int QUEUE_DEPTH      = 4;
  localparam int MAX_RES          = 3;

  // message kind codes
  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_BULK   = 2'd2;

  // run status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NO_CRLF  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_LEN_OVF  = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;
  localparam logic [2:0] ST_BAD_TAIL = 3'd6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [1:0] msg_kind;
    logic       run_last;
    logic [2:0] status;
  } out_item_t;

  // one result as produced by the front, kind is shared per bundle
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
    logic       is_last;
    logic [2:0] status;
  } res_ent_t;

  // all results caused by one input item
  typedef struct packed {
    logic [1:0]                 kind;
    logic [1:0]                 cnt;
    res_ent_t [MAX_RES-1:0]     ent;
  } bundle_t;

endpackage

// ===== rtl/rfp_front.sv =====
// rfp_front: byte classifier and frame state machine
// turns each accepted item that causes results into a bundle of up to three results; uses rfp_pkg
module rfp_front #(
  parameter int LENGTH_WIDTH = rfp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rfp_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push_valid,
  output rfp_pkg::bundle_t  push_data
);
  import rfp_pkg::*;

  localparam int LW = LENGTH_WIDTH;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // saturation value 2^LW + 1
  localparam logic [LW+3:0] SAT = {3'b000, 1'b1, {(LW-1){1'b0}}, 1'b1};

  typedef enum logic [8:0] {
    PH_AWAIT    = 9'b0_0000_0001,
    PH_TEXT     = 9'b0_0000_0010,
    PH_LEN_LEAD = 9'b0_0000_0100,
    PH_LEN_NUM  = 9'b0_0000_1000,
    PH_LEN_TAIL = 9'b0_0001_0000,
    PH_DATA     = 9'b0_0010_0000,
    PH_TRAIL_CR = 9'b0_0100_0000,
    PH_TRAIL_LF = 9'b0_1000_0000,
    PH_SKIP     = 9'b1_0000_0000
  } phase_t;

  phase_t          phase_r, phase_nxt, lph;
  logic [1:0]      kind_r, kind_nxt;
  logic            crp_r, crp_nxt;
  logic            neg_r, neg_nxt;
  logic            dig_r, dig_nxt;
  logic [LW:0]     acc_r, acc_nxt;
  logic [LW-1:0]   bl_r, bl_nxt;

  logic [7:0]      c;
  logic            is_dig;
  logic [LW+3:0]   prod;
  logic [LW:0]     acc_dig;
  logic            over;
  logic            stop;
  logic [1:0]      n;
  res_ent_t [MAX_RES-1:0] ents;
  logic            accept;

  function automatic res_ent_t mk_data(input logic [7:0] ch);
    res_ent_t e;
    e.data_byte = ch;
    e.is_data   = 1'b1;
    e.is_last   = 1'b0;
    e.status    = ST_OK;
    return e;
  endfunction

  function automatic res_ent_t mk_close(input logic [2:0] st);
    res_ent_t e;
    e.data_byte = 8'h00;
    e.is_data   = 1'b0;
    e.is_last   = 1'b1;
    e.status    = st;
    return e;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  assign c      = in_data.in_byte;
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  // acc * 10 + digit, saturated
  assign prod    = ({3'b000, acc_r} << 3) + ({3'b000, acc_r} << 1)
                 + {{LW{1'b0}}, c[3:0]};
  assign acc_dig = (prod > SAT) ? SAT[LW:0] : prod[LW:0];
  assign over    = neg_r ? (acc_r[LW] && (|acc_r[LW-1:0])) : acc_r[LW];

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    crp_nxt   = crp_r;
    neg_nxt   = neg_r;
    dig_nxt   = dig_r;
    acc_nxt   = acc_r;
    bl_nxt    = bl_r;
    lph       = phase_r;
    stop      = 1'b0;
    n         = 2'd0;
    ents      = '0;

    unique case (phase_r)
      PH_AWAIT: begin
        if (c == CH_PLUS) begin
          kind_nxt  = KIND_SIMPLE;
          phase_nxt = PH_TEXT;
        end else if (c == CH_MINUS) begin
          kind_nxt  = KIND_ERROR;
          phase_nxt = PH_TEXT;
        end else if (c == CH_DOLLAR) begin
          kind_nxt  = KIND_BULK;
          phase_nxt = PH_LEN_LEAD;
        end else begin
          kind_nxt  = KIND_SIMPLE;
          ents[n]   = mk_close(ST_EMPTY);
          n         = n + 2'd1;
          phase_nxt = PH_SKIP;
        end
      end
      PH_TEXT: begin
        if (crp_r) begin
          crp_nxt = 1'b0;
          if (c == CH_LF) begin
            ents[n]   = mk_close(ST_OK);
            n         = n + 2'd1;
            phase_nxt = PH_SKIP;
            stop      = 1'b1;
          end else begin
            ents[n] = mk_data(CH_CR);
            n       = n + 2'd1;
          end
        end
        if (!stop) begin
          if (c == CH_CR) begin
            crp_nxt = 1'b1;
          end else begin
            ents[n] = mk_data(c);
            n       = n + 2'd1;
          end
        end
      end
      PH_LEN_LEAD, PH_LEN_NUM, PH_LEN_TAIL: begin
        if (crp_r) begin
          crp_nxt = 1'b0;
          if (c == CH_LF) begin
            stop = 1'b1;
            if (!dig_r) begin
              ents[n]   = mk_close(ST_BAD_LEN);
              n         = n + 2'd1;
              phase_nxt = PH_SKIP;
            end else if (over) begin
              ents[n]   = mk_close(ST_LEN_OVF);
              n         = n + 2'd1;
              phase_nxt = PH_SKIP;
            end else if (neg_r && (|acc_r)) begin
              ents[n]   = mk_close(ST_EMPTY);
              n         = n + 2'd1;
              phase_nxt = PH_SKIP;
            end else begin
              bl_nxt    = acc_r[LW-1:0];
              phase_nxt = (|acc_r[LW-1:0]) ? PH_DATA : PH_TRAIL_CR;
            end
          end else if (phase_r == PH_LEN_NUM) begin
            // held-back CR ends the digit run
            lph = PH_LEN_TAIL;
          end
        end
        if (!stop) begin
          phase_nxt = lph;
          if (c == CH_CR) begin
            crp_nxt = 1'b1;
          end else begin
            unique case (lph)
              PH_LEN_LEAD: begin
                if (!is_space(c)) begin
                  if (c == CH_PLUS || c == CH_MINUS) begin
                    neg_nxt   = (c == CH_MINUS);
                    phase_nxt = PH_LEN_NUM;
                  end else if (is_dig) begin
                    acc_nxt   = acc_dig;
                    dig_nxt   = 1'b1;
                    phase_nxt = PH_LEN_NUM;
                  end else begin
                    phase_nxt = PH_LEN_TAIL;
                  end
                end
              end
              PH_LEN_NUM: begin
                if (is_dig) begin
                  acc_nxt = acc_dig;
                  dig_nxt = 1'b1;
                end else begin
                  phase_nxt = PH_LEN_TAIL;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      PH_DATA: begin
        ents[n] = mk_data(c);
        n       = n + 2'd1;
        bl_nxt  = bl_r - {{(LW-1){1'b0}}, 1'b1};
        if (bl_r == {{(LW-1){1'b0}}, 1'b1}) begin
          phase_nxt = PH_TRAIL_CR;
        end
      end
      PH_TRAIL_CR: begin
        if (c == CH_CR) begin
          phase_nxt = PH_TRAIL_LF;
        end else begin
          ents[n]   = mk_close(ST_BAD_TAIL);
          n         = n + 2'd1;
          phase_nxt = PH_SKIP;
        end
      end
      PH_TRAIL_LF: begin
        ents[n]   = mk_close((c == CH_LF) ? ST_OK : ST_BAD_TAIL);
        n         = n + 2'd1;
        phase_nxt = PH_SKIP;
      end
      default: begin
      end
    endcase

    push_data.kind = kind_nxt;

    if (in_data.frame_end) begin
      unique case (phase_nxt) inside
        PH_TEXT, PH_LEN_LEAD, PH_LEN_NUM, PH_LEN_TAIL: begin
          ents[n] = mk_close(ST_NO_CRLF);
          n       = n + 2'd1;
        end
        PH_DATA: begin
          ents[n] = mk_close(ST_SHORT);
          n       = n + 2'd1;
        end
        PH_TRAIL_CR, PH_TRAIL_LF: begin
          ents[n] = mk_close(ST_BAD_TAIL);
          n       = n + 2'd1;
        end
        default: begin
        end
      endcase
      // frame end always returns to the idle state
      phase_nxt = PH_AWAIT;
      kind_nxt  = KIND_SIMPLE;
      crp_nxt   = 1'b0;
      neg_nxt   = 1'b0;
      dig_nxt   = 1'b0;
      acc_nxt   = '0;
      bl_nxt    = '0;
    end

    push_data.cnt = n;
    push_data.ent = ents;
  end

  assign push_valid = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_AWAIT;
      kind_r  <= KIND_SIMPLE;
      crp_r   <= 1'b0;
      neg_r   <= 1'b0;
      dig_r   <= 1'b0;
      acc_r   <= '0;
      bl_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      crp_r   <= crp_nxt;
      neg_r   <= neg_nxt;
      dig_r   <= dig_nxt;
      acc_r   <= acc_nxt;
      bl_r    <= bl_nxt;
    end
  end

endmodule

// ===== rtl/rfp_queue.sv =====
// rfp_queue: short queue of result bundles between front and back
// register array with head read; uses rfp_pkg
module rfp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  rfp_pkg::bundle_t push_data,
  output logic             q_full,
  output logic             q_valid,
  output rfp_pkg::bundle_t q_data,
  input  logic             q_pop
);
  import rfp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  bundle_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign q_full  = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rfp_back.sv =====
// rfp_back: unpacks bundles into single result items
// one result per cycle into the output register while out_stall is low; uses rfp_pkg
module rfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rfp_pkg::bundle_t   q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rfp_pkg::out_item_t out_data
);
  import rfp_pkg::*;

  logic [1:0]  idx_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        load;
  logic        last_ent;
  res_ent_t    cur;

  assign cur      = q_data.ent[idx_r];
  assign load     = q_valid && (!out_valid_r || !out_stall);
  assign last_ent = (idx_r == (q_data.cnt - 2'd1));
  assign q_pop    = load && last_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= last_ent ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.payload_byte  <= cur.data_byte;
      out_data_r.payload_valid <= cur.is_data;
      out_data_r.msg_kind      <= q_data.kind;
      out_data_r.run_last      <= cur.is_last;
      out_data_r.status        <= cur.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/resp_frame_parser.sv =====
// resp_frame_parser: byte-serial parser for single text/error/bulk frames
// path: the results of a byte pass through the queue and then the output register before they show on out_,
//   further results of the same byte follow one per cycle while out_stall is low
// throughput: one byte per cycle in while the queue has room, one result per cycle out while out_stall
//   is low; a byte can raise up to three results, so the output register sets the sustained rate
// reset: rst_n synchronous active low, clears the frame state and the queue
module resp_frame_parser #(
  parameter int LENGTH_WIDTH = rfp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rfp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rfp_pkg::out_item_t out_data
);
  import rfp_pkg::*;

  // front to queue
  logic    push_valid;
  bundle_t push_data;
  logic    q_full;

  // queue to back
  logic    q_valid;
  bundle_t q_data;
  logic    q_pop;

  // front: frame state machine, one byte per cycle while the queue has room;
  // every byte that causes results leaves one bundle of them
  rfp_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // queue: decouples the byte side from output back-pressure
  rfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  // back: walks each bundle, one result item per cycle into the output register while out_stall is low
  rfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/rfp_checker.sv =====
// rfp_checker: port-level checks for resp_frame_parser, bound to the top level
// uses rfp_pkg status codes and item types
module rfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rfp_pkg::out_item_t out_data
);
  import rfp_pkg::*;

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled item does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // every item is either a data byte or the closing item of a run
  a_data_or_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.payload_valid != out_data.run_last))
    else $error("item is neither data nor run close");

  // data items always carry ok status
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_valid |-> out_data.status == ST_OK)
    else $error("data item with error status");

  // the queue is empty straight after reset, so input is taken
  a_ready_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind resp_frame_parser rfp_checker u_rfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
